// ----- design/ffsd_pkg.sv -----
package ffsd_pkg;

  // Fixed widths of the ports
  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 23;
  localparam int WORD_W  = 32;
  localparam int MANT_W  = 24;

  localparam logic [FIELD_W-1:0] THRESHOLD_RESET = 23'd20480;

  // Single-precision patterns
  localparam logic [WORD_W-1:0] NEG_ZERO_BITS = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LIMIT_BITS    = 32'h44FA_0000; // 2000.0

  // Exponent at which the integer part of the significand is the value
  localparam int EXP_UNIT_SHIFT = 150;

  // Converter status toward the sequencer
  typedef struct packed {
    logic done;
    logic ok;
  } ffsd_conv_stat_t;

endpackage

// ----- design/ffsd_ram.sv -----
module ffsd_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/ffsd_f2x.sv -----
module ffsd_f2x
  import ffsd_pkg::*;
#(
  parameter int FRACTION_BITS = 12,
  parameter int VAL_W         = 23
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] word,
  output ffsd_conv_stat_t   stat,
  output logic [VAL_W-1:0]  value
);

  localparam int CONV_W     = (VAL_W > MANT_W) ? VAL_W : MANT_W;
  localparam int SHIFT_ZERO = EXP_UNIT_SHIFT - FRACTION_BITS;

  logic [7:0]        expo;
  logic              neg_zero;
  logic              ok_in;
  logic              go_left;
  logic [8:0]        left_amt;
  logic [8:0]        right_amt;
  logic              to_zero;

  logic              busy_r;
  logic              ok_r;
  logic              left_r;
  logic [4:0]        cnt_r;
  logic [CONV_W-1:0] mant_r;

  always_comb begin
    expo      = word[30:23];
    neg_zero  = (word == NEG_ZERO_BITS);
    ok_in     = neg_zero || (!word[31] && (word < LIMIT_BITS));
    go_left   = 9'(expo) > 9'(SHIFT_ZERO);
    left_amt  = 9'(expo) - 9'(SHIFT_ZERO);
    right_amt = 9'(SHIFT_ZERO) - 9'(expo);
    // Anything shifted right past the whole significand truncates to zero
    to_zero   = !ok_in || neg_zero || (expo == 8'd0) ||
                (!go_left && (right_amt >= 9'(MANT_W)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      ok_r   <= ok_in;
      left_r <= go_left;
      if (to_zero) begin
        mant_r <= '0;
        cnt_r  <= '0;
      end else begin
        mant_r <= CONV_W'({1'b1, word[22:0]});
        cnt_r  <= go_left ? 5'(left_amt) : 5'(right_amt);
      end
    end else if (busy_r) begin
      if (cnt_r != 5'd0) begin
        // Move one bit position per cycle
        mant_r <= left_r ? (mant_r << 1) : (mant_r >> 1);
        cnt_r  <= cnt_r - 5'd1;
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  assign stat.done = busy_r && (cnt_r == 5'd0);
  assign stat.ok   = ok_r;
  assign value     = VAL_W'(mant_r);

endmodule

// ----- design/ffsd_div.sv -----
module ffsd_div #(
  parameter int DIVIDEND_W = 27,
  parameter int DIVISOR_W  = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  div_r;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // Restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_r, quo_r[DIVIDEND_W-1]};
    fits  = trial >= {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIVIDEND_W);
      quo_r  <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        rem_r <= fits ? DIVISOR_W'(trial - {1'b0, div_r}) : DIVISOR_W'(trial);
        quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
        cnt_r <= cnt_r - CNT_W'(1);
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done     = busy_r && (cnt_r == '0);
  assign quotient = quo_r;

endmodule

// ----- design/float_frame_spike_detector.sv -----
// Spike detector for a stream of single-precision readings sent as bytes.
//
// Input channel (in_valid / in_ready / in_data_byte): one byte per beat,
// most significant byte of each 4-byte big-endian float first. Bytes one to
// three are held in the assembler. The fourth completes a frame; frames
// that are NaN, infinite, negative (minus zero counts as zero) or at least
// 2000.0 give no result. A good frame is converted to fixed point with
// FRACTION_BITS fraction bits, pushed into a WINDOW_DEPTH-deep window and
// the window average is formed by a bit-serial divider.
// Output channel (out_valid / out_ready): reading, spike flag and new
// baseline, held in an output register until taken.
// After the fourth byte, the float conversion shifts bit-serially by N
// (0 to 23), the window is updated and the divider works through the
// SUM_W bits of the window sum. in_ready is low while a frame is
// converted and averaged. Bytes of the next frame are taken while a
// result waits, but its fourth byte stalls until out_ready.
// cfg_write_en writes the spike threshold at once; write only when idle.
// Reset (rst_n, synchronous) clears the frame assembler, window count,
// sum and threshold (to 5.0); window storage is not cleared.
module float_frame_spike_detector
  import ffsd_pkg::*;
#(
  parameter int WINDOW_DEPTH  = 16,
  parameter int FRACTION_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BYTE_W-1:0]  in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] out_field_value,
  output logic               out_spike,
  output logic [FIELD_W-1:0] out_baseline_value,
  input  logic               cfg_write_en,
  input  logic [FIELD_W-1:0] cfg_spike_threshold
);

  // Readings stay below 2000, i.e. below 2^11 before the fraction
  localparam int VAL_W  = 11 + FRACTION_BITS;
  localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = VAL_W + $clog2(WINDOW_DEPTH);
  localparam int CMP_W  = (VAL_W > FIELD_W) ? VAL_W : FIELD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SUB,
    S_ADD,
    S_DIV
  } state_t;

  state_t               state_r, state_nxt;
  logic [23:0]          frame_r, frame_nxt;
  logic [1:0]           pos_r, pos_nxt;
  logic [FIELD_W-1:0]   thr_r, thr_nxt;
  logic [PTR_W-1:0]     wptr_r, wptr_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0]   out_field_r, out_field_nxt;
  logic                 out_spike_r, out_spike_nxt;
  logic [FIELD_W-1:0]   out_base_r, out_base_nxt;

  logic                 in_acc;
  logic                 conv_start;
  logic [WORD_W-1:0]    conv_word;
  ffsd_conv_stat_t      conv_stat;
  logic [VAL_W-1:0]     conv_value;
  logic                 ram_we;
  logic [VAL_W-1:0]     old_sample;
  logic                 div_start;
  logic                 div_done;
  logic [SUM_W-1:0]     div_quo;

  assign in_ready   = (state_r == S_IDLE) && !((pos_r == 2'd3) && out_valid_r);
  assign in_acc     = in_valid && in_ready;
  assign conv_start = in_acc && (pos_r == 2'd3);
  assign conv_word  = {frame_r, in_data_byte};
  assign ram_we     = (state_r == S_ADD);
  assign div_start  = (state_r == S_ADD);

  ffsd_f2x #(
    .FRACTION_BITS (FRACTION_BITS),
    .VAL_W         (VAL_W)
  ) u_f2x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .word  (conv_word),
    .stat  (conv_stat),
    .value (conv_value)
  );

  // Read address sits on the write pointer: the oldest sample is ready
  // long before the window update needs it.
  ffsd_ram #(
    .WIDTH (VAL_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr_r),
    .wdata (val_r),
    .raddr (wptr_r),
    .rdata (old_sample)
  );

  ffsd_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (FILL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (fill_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    frame_nxt     = frame_r;
    pos_nxt       = pos_r;
    thr_nxt       = thr_r;
    wptr_nxt      = wptr_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r;
    out_field_nxt = out_field_r;
    out_spike_nxt = out_spike_r;
    out_base_nxt  = out_base_r;

    if (cfg_write_en) begin
      thr_nxt = cfg_spike_threshold;
    end

    // Drop the result once the receiver takes it
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Gather bytes; the fourth one hands the frame to the converter
    if (in_acc) begin
      if (pos_r == 2'd3) begin
        frame_nxt = '0;
        pos_nxt   = 2'd0;
      end else begin
        frame_nxt = {frame_r[15:0], in_data_byte};
        pos_nxt   = pos_r + 2'd1;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (conv_start) begin
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        if (conv_stat.done) begin
          if (conv_stat.ok) begin
            val_nxt   = conv_value;
            state_nxt = S_SUB;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SUB: begin
        // A full window loses its oldest sample
        if (fill_r == FILL_W'(WINDOW_DEPTH)) begin
          sum_nxt = sum_r - SUM_W'(old_sample);
        end else begin
          fill_nxt = fill_r + FILL_W'(1);
        end
        state_nxt = S_ADD;
      end
      S_ADD: begin
        sum_nxt = sum_r + SUM_W'(val_r);
        if (wptr_r == PTR_W'(WINDOW_DEPTH - 1)) begin
          wptr_nxt = '0;
        end else begin
          wptr_nxt = wptr_r + PTR_W'(1);
        end
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          out_valid_nxt = 1'b1;
          out_field_nxt = FIELD_W'(val_r);
          // Spike flag: the reading itself above threshold. Baseline is never
          // negative, so any deviation above threshold also sets the flag
          out_spike_nxt = CMP_W'(val_r) > CMP_W'(thr_r);
          out_base_nxt  = FIELD_W'(div_quo);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frame_r     <= '0;
      pos_r       <= '0;
      thr_r       <= THRESHOLD_RESET;
      wptr_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frame_r     <= frame_nxt;
      pos_r       <= pos_nxt;
      thr_r       <= thr_nxt;
      wptr_r      <= wptr_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    out_field_r <= out_field_nxt;
    out_spike_r <= out_spike_nxt;
    out_base_r  <= out_base_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_field_value    = out_field_r;
  assign out_spike          = out_spike_r;
  assign out_baseline_value = out_base_r;

endmodule
